>>> rtl/sso_pkg.sv
package sso_pkg;

  // Capacity of each set, the element width and the widths that follow from the capacity.
  localparam int SET_SIZE = 32;
  localparam int DW       = 32;
  localparam int AW       = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CW       = $clog2(SET_SIZE + 1);
  localparam int RW       = $clog2(2 * SET_SIZE + 1);

  typedef enum logic [1:0] {
    OP_UNION     = 2'd0,
    OP_INTER     = 2'd1,
    OP_A_MINUS_B = 2'd2,
    OP_SYM_DIFF  = 2'd3
  } set_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INS_CHK,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_MRG_CHK0,
    ST_MRG_CMP0,
    ST_MRG_CHK1,
    ST_MRG_CMP1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_rd;
    logic scan_dec;
    logic set_ovf;
    logic shift_init;
    logic shift_wr;
    logic write_new;
    logic mrg_start;
    logic mrg_restart;
    logic mrg_rd;
    logic mrg_step;
    logic emit_pass;
    logic emit_empty;
    logic clear_sets;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_sel_zero;
    logic sel_full;
    logic scan_eq;
    logic scan_lt;
    logic scan_k_one;
    logic sh_at_pos;
    logic end_pend;
    logic mrg_done;
    logic rcount_zero;
  } dp_status_t;

endpackage

>>> rtl/sorted_set_operations_top.sv
// An element transaction holds busy while it scans the set and, if inserted, shifts entries up.
// An end transaction runs a counting merge over the distinct elements in A and B,
// then, unless the result is empty, an emitting pass over the same merge.
// One transaction at a time; busy stays high until all results are out.
// Reset (rst_n low, synchronous): both sets empty, overflow cleared, operation union.
// Results are strobed for one cycle on out_valid; there is no stall.
//
// Both sets live in single-port-read memories that are kept sorted in ascending signed
// order at load time. A load first scans the selected set from its top entry downward to
// find either a duplicate (the element is dropped) or the insertion point. If the set is
// full and no duplicate exists, the overflow flag is raised. Otherwise entries above the
// insertion point move up one place, each by a read and then a write, and the new
// element is written into the hole.
//
// On an end transaction the two sorted sets are merged twice. The first pass only counts
// the result elements and decides whether A is a subset of B, since every result
// transaction reports that flag and the last one carries the last marker. The second pass
// walks the same merge and emits the chosen elements. An empty result gives a single
// transaction with the empty and last markers set. Afterwards both sets and the overflow
// flag are cleared for the next load.
module sorted_set_operations_top import sso_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] in_element_value,
  input  logic                 in_which_set,
  input  logic                 in_carries_element,
  input  logic                 in_end_of_load,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_result_value,
  output logic                 out_result_last,
  output logic                 out_result_empty,
  output logic                 out_a_within_b,
  output logic                 out_overflow_seen
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences scan, insert and the two merge passes.
  sso_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_carries_element (in_carries_element),
    .in_end_of_load     (in_end_of_load),
    .status             (status),
    .cmd                (cmd),
    .busy               (busy)
  );

  // The datapath holds the two set memories, counters and the result register.
  sso_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_element_value  (in_element_value),
    .in_which_set      (in_which_set),
    .in_end_of_load    (in_end_of_load),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_result_last   (out_result_last),
    .out_result_empty  (out_result_empty),
    .out_a_within_b    (out_a_within_b),
    .out_overflow_seen (out_overflow_seen)
  );

endmodule

>>> rtl/sso_ctrl.sv
module sso_ctrl import sso_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_carries_element,
  input  logic       in_end_of_load,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t load_next;

  assign busy      = (state_r != ST_IDLE);
  assign load_next = status.end_pend ? ST_MRG_CHK0 : ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_carries_element) begin
            state_nxt = ST_SCAN_INIT;
          end else if (in_end_of_load) begin
            state_nxt = ST_MRG_CHK0;
          end
        end
      end
      ST_SCAN_INIT: state_nxt = status.cnt_sel_zero ? ST_INS_CHK : ST_SCAN_RD;
      ST_SCAN_RD:   state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (status.scan_eq) begin
          state_nxt = load_next;
        end else if (status.scan_lt || status.scan_k_one) begin
          state_nxt = ST_INS_CHK;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_INS_CHK:   state_nxt = status.sel_full ? load_next : ST_SHIFT_CHK;
      ST_SHIFT_CHK: state_nxt = status.sh_at_pos ? load_next : ST_SHIFT_WR;
      ST_SHIFT_WR:  state_nxt = ST_SHIFT_CHK;
      ST_MRG_CHK0: begin
        if (status.mrg_done) begin
          state_nxt = status.rcount_zero ? ST_IDLE : ST_MRG_CHK1;
        end else begin
          state_nxt = ST_MRG_CMP0;
        end
      end
      ST_MRG_CMP0:  state_nxt = ST_MRG_CHK0;
      ST_MRG_CHK1:  state_nxt = status.mrg_done ? ST_IDLE : ST_MRG_CMP1;
      ST_MRG_CMP1:  state_nxt = ST_MRG_CHK1;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept    = start;
        cmd.mrg_start = start && !in_carries_element && in_end_of_load;
      end
      ST_SCAN_INIT: cmd.scan_init = 1'b1;
      ST_SCAN_RD:   cmd.scan_rd   = 1'b1;
      ST_SCAN_CMP: begin
        cmd.scan_dec  = !status.scan_eq && !status.scan_lt;
        cmd.mrg_start = status.scan_eq && status.end_pend;
      end
      ST_INS_CHK: begin
        cmd.set_ovf    = status.sel_full;
        cmd.mrg_start  = status.sel_full && status.end_pend;
        cmd.shift_init = !status.sel_full;
      end
      ST_SHIFT_CHK: begin
        cmd.write_new = status.sh_at_pos;
        cmd.mrg_start = status.sh_at_pos && status.end_pend;
      end
      ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      ST_MRG_CHK0: begin
        cmd.mrg_rd      = !status.mrg_done;
        cmd.emit_empty  = status.mrg_done && status.rcount_zero;
        cmd.clear_sets  = status.mrg_done && status.rcount_zero;
        cmd.mrg_restart = status.mrg_done && !status.rcount_zero;
      end
      ST_MRG_CMP0: cmd.mrg_step = 1'b1;
      ST_MRG_CHK1: begin
        cmd.mrg_rd     = !status.mrg_done;
        cmd.clear_sets = status.mrg_done;
      end
      ST_MRG_CMP1: begin
        cmd.mrg_step  = 1'b1;
        cmd.emit_pass = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/sso_dp.sv
module sso_dp import sso_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic signed [DW-1:0] in_element_value,
  input  logic                 in_which_set,
  input  logic                 in_end_of_load,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_result_value,
  output logic                 out_result_last,
  output logic                 out_result_empty,
  output logic                 out_a_within_b,
  output logic                 out_overflow_seen
);

  logic [DW-1:0] mem_a [SET_SIZE];
  logic [DW-1:0] mem_b [SET_SIZE];
  logic [DW-1:0] rdata_a_r, rdata_b_r;

  set_op_t       op_r;
  logic [DW-1:0] val_r;
  logic          set_r, end_r;
  logic [CW-1:0] cnt_a_r, cnt_b_r, k_r, sh_r, i_r, j_r;
  logic          ovf_r, subset_r;
  logic [RW-1:0] rcnt_r, ecnt_r;

  logic                 out_valid_r, out_last_r, out_empty_r, out_within_r, out_ovf_r;
  logic signed [DW-1:0] out_value_r;

  logic [CW-1:0] cnt_sel, ld_addr_full;
  logic [AW-1:0] ld_addr, addr_a, addr_b, wr_addr;
  logic [DW-1:0] rd_sel, wr_data, elem;
  logic          we_a, we_b;
  logic          a_left, b_left, take_a, take_b, incl;

  assign cnt_sel      = set_r ? cnt_b_r : cnt_a_r;
  assign rd_sel       = set_r ? rdata_b_r : rdata_a_r;
  assign ld_addr_full = (cmd.scan_rd ? k_r : sh_r) - CW'(1);
  assign ld_addr      = ld_addr_full[AW-1:0];
  assign addr_a       = cmd.mrg_rd ? i_r[AW-1:0] : ld_addr;
  assign addr_b       = cmd.mrg_rd ? j_r[AW-1:0] : ld_addr;
  assign wr_addr      = cmd.shift_wr ? sh_r[AW-1:0] : k_r[AW-1:0];
  assign wr_data      = cmd.shift_wr ? rd_sel : val_r;
  assign we_a         = (cmd.shift_wr || cmd.write_new) && !set_r;
  assign we_b         = (cmd.shift_wr || cmd.write_new) && set_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rdata_a_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rdata_b_r <= mem_b[addr_b];
  end

  // Merge step decision on the two heads read last cycle.
  assign a_left = (i_r != cnt_a_r);
  assign b_left = (j_r != cnt_b_r);
  assign take_a = !b_left || (a_left && ($signed(rdata_a_r) < $signed(rdata_b_r)));
  assign take_b = !take_a && (!a_left || ($signed(rdata_b_r) < $signed(rdata_a_r)));
  assign elem   = take_b ? rdata_b_r : rdata_a_r;

  always_comb begin
    if (take_a) begin
      incl = (op_r != OP_INTER);
    end else if (take_b) begin
      incl = (op_r == OP_UNION) || (op_r == OP_SYM_DIFF);
    end else begin
      incl = (op_r == OP_UNION) || (op_r == OP_INTER);
    end
  end

  assign status.cnt_sel_zero = (cnt_sel == '0);
  assign status.sel_full     = (cnt_sel == CW'(SET_SIZE));
  assign status.scan_eq      = (rd_sel == val_r);
  assign status.scan_lt      = ($signed(rd_sel) < $signed(val_r));
  assign status.scan_k_one   = (k_r == CW'(1));
  assign status.sh_at_pos    = (sh_r == k_r);
  assign status.end_pend     = end_r;
  assign status.mrg_done     = !a_left && !b_left;
  assign status.rcount_zero  = (rcnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_UNION;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        op_r <= set_op_t'(cfg_wdata);
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.write_new) begin
        if (set_r) begin
          cnt_b_r <= cnt_b_r + CW'(1);
        end else begin
          cnt_a_r <= cnt_a_r + CW'(1);
        end
      end
      if (cmd.clear_sets) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r <= in_element_value;
      set_r <= in_which_set;
      end_r <= in_end_of_load;
    end
    if (cmd.scan_init) begin
      k_r <= cnt_sel;
    end else if (cmd.scan_dec) begin
      k_r <= k_r - CW'(1);
    end
    if (cmd.shift_init) begin
      sh_r <= cnt_sel;
    end else if (cmd.shift_wr) begin
      sh_r <= sh_r - CW'(1);
    end
    if (cmd.mrg_start || cmd.mrg_restart) begin
      i_r    <= '0;
      j_r    <= '0;
      ecnt_r <= '0;
    end else if (cmd.mrg_step) begin
      if (!take_b) begin
        i_r <= i_r + CW'(1);
      end
      if (!take_a) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.emit_pass && incl) begin
        ecnt_r <= ecnt_r + RW'(1);
      end
    end
    if (cmd.mrg_start) begin
      subset_r <= 1'b1;
      rcnt_r   <= '0;
    end else if (cmd.mrg_step && !cmd.emit_pass) begin
      if (take_a) begin
        subset_r <= 1'b0;
      end
      if (incl) begin
        rcnt_r <= rcnt_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_empty || (cmd.mrg_step && cmd.emit_pass && incl);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
      out_empty_r  <= 1'b1;
      out_within_r <= subset_r;
      out_ovf_r    <= ovf_r;
    end else if (cmd.mrg_step && cmd.emit_pass && incl) begin
      out_value_r  <= $signed(elem);
      out_last_r   <= ((ecnt_r + RW'(1)) == rcnt_r);
      out_empty_r  <= 1'b0;
      out_within_r <= subset_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_result_last   = out_last_r;
  assign out_result_empty  = out_empty_r;
  assign out_a_within_b    = out_within_r;
  assign out_overflow_seen = out_ovf_r;

endmodule
